// ----- hdl/utf8_to_utf32_stream_decoder_assert.svh -----
// assertion macros for the utf-8 to utf-32 stream decoder
// used by the top level only, no other dependencies
`ifndef UTF8_TO_UTF32_STREAM_DECODER_ASSERT_SVH
`define UTF8_TO_UTF32_STREAM_DECODER_ASSERT_SVH

// same-cycle implication under reset
`define U2U_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication under reset
`define U2U_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/u2u_pkg.sv -----
// shared types, constants and helper functions of the utf-8 decoder
// no dependencies
package u2u_pkg;

  localparam longint unsigned MaxStringBytes = 64'd65535;
  localparam int unsigned CountW = 16;
  localparam logic [CountW-1:0] CountCap =
    (MaxStringBytes < 64'd65535) ? CountW'(MaxStringBytes) : {CountW{1'b1}};

  localparam logic [7:0] AsciiLimit = 8'h80;
  localparam logic [7:0] LeadLow    = 8'hC0;
  localparam logic [7:0] LeadHigh   = 8'hF7;
  localparam logic [7:0] Lead2Mask  = 8'hE0;
  localparam logic [7:0] Lead2Code  = 8'hC0;
  localparam logic [7:0] Lead2Bits  = 8'h1F;
  localparam logic [7:0] Lead3Mask  = 8'hF0;
  localparam logic [7:0] Lead3Code  = 8'hE0;
  localparam logic [7:0] Lead3Bits  = 8'h0F;
  localparam logic [7:0] Lead4Bits  = 8'h07;
  localparam logic [7:0] ContBits   = 8'h3F;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_LEAD = 2'd1,
    ST_TRUNC    = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_string;
  } in_item_t;

  typedef struct packed {
    logic [31:0]       char_word;
    logic              word_valid;
    status_t           status;
    logic              done_res;
    logic [CountW-1:0] consumed;
  } res_t;

  function automatic logic [CountW-1:0] bump(input logic [CountW-1:0] v);
    return (v < CountCap) ? v + CountW'(1) : CountCap;
  endfunction

  function automatic logic [31:0] byte_swap(input logic [31:0] w);
    return {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

endpackage

// ----- hdl/u2u_if.sv -----
// valid/ready channel interfaces for input bytes and decoded results
// no dependencies
interface u2u_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_string;

  modport source (output valid, output data_byte, output end_of_string, input ready);
  modport sink (input valid, input data_byte, input end_of_string, output ready);
endinterface

interface u2u_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] char_word;
  logic        word_valid;
  logic [1:0]  status;
  logic        done_res;
  logic [15:0] consumed;

  modport source (output valid, output char_word, output word_valid, output status,
                  output done_res, output consumed, input ready);
  modport sink (input valid, input char_word, input word_valid, input status,
                input done_res, input consumed, output ready);
endinterface

// ----- hdl/u2u_in_stage.sv -----
// input register stage: one byte item per cycle from the input channel while
// no item is held or the held one is taken; depends on u2u_pkg and u2u_in_if
module u2u_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  u2u_in_if.sink            in_ch,
  input  logic              take,
  output logic              item_valid,
  output u2u_pkg::in_item_t item
);
  import u2u_pkg::*;

  logic     valid_r;
  logic     valid_nxt;
  in_item_t item_r;
  logic     accept;

  assign in_ch.ready = !valid_r || take;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= '{data_byte: in_ch.data_byte, end_of_string: in_ch.end_of_string};
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;
endmodule

// ----- hdl/u2u_decode.sv -----
// string state and byte decode: lead classification, accumulation, end handling
// depends on u2u_pkg
module u2u_decode (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              swap,
  input  logic              fire,
  input  u2u_pkg::in_item_t item,
  output logic              has_res,
  output u2u_pkg::res_t     res
);
  import u2u_pkg::*;

  logic [20:0]       acc_r, acc_nxt;
  logic [1:0]        pend_r, pend_nxt;
  logic [CountW-1:0] pos_r, pos_nxt;
  logic [CountW-1:0] seq_r, seq_nxt;
  logic              skip_r, skip_nxt;

  logic [7:0]        b;
  logic              eos;
  logic [CountW-1:0] pos_inc;
  logic [20:0]       acc_cont;
  logic [31:0]       word;
  logic              clear;

  assign b        = item.data_byte;
  assign eos      = item.end_of_string;
  assign pos_inc  = bump(pos_r);
  assign acc_cont = {acc_r[14:0], 6'(b & ContBits)};

  always_comb begin
    acc_nxt  = acc_r;
    pend_nxt = pend_r;
    pos_nxt  = pos_r;
    seq_nxt  = seq_r;
    skip_nxt = skip_r;
    has_res  = 1'b0;
    word     = '0;
    clear    = 1'b0;
    res      = '{char_word: '0, word_valid: 1'b0, status: ST_OK, done_res: 1'b0,
                 consumed: '0};
    priority if (skip_r) begin
      clear = eos;
    end else if (pend_r != 2'd0) begin
      acc_nxt  = acc_cont;
      pend_nxt = pend_r - 2'd1;
      pos_nxt  = pos_inc;
      if (pend_r == 2'd1) begin
        has_res        = 1'b1;
        word           = {11'd0, acc_cont};
        res.word_valid = 1'b1;
        res.done_res   = eos;
        res.consumed   = eos ? pos_inc : '0;
        clear          = eos;
      end else if (eos) begin
        has_res      = 1'b1;
        res.status   = ST_TRUNC;
        res.done_res = 1'b1;
        res.consumed = seq_r;
        clear        = 1'b1;
      end
    end else if (b < AsciiLimit) begin
      pos_nxt        = pos_inc;
      has_res        = 1'b1;
      word           = {24'd0, b};
      res.word_valid = 1'b1;
      res.done_res   = eos;
      res.consumed   = eos ? pos_inc : '0;
      clear          = eos;
    end else if (b < LeadLow || b > LeadHigh) begin
      has_res      = 1'b1;
      res.status   = ST_BAD_LEAD;
      res.done_res = 1'b1;
      res.consumed = pos_r;
      clear        = 1'b1;
    end else begin
      if ((b & Lead2Mask) == Lead2Code) begin
        acc_nxt  = {13'd0, b & Lead2Bits};
        pend_nxt = 2'd1;
      end else if ((b & Lead3Mask) == Lead3Code) begin
        acc_nxt  = {13'd0, b & Lead3Bits};
        pend_nxt = 2'd2;
      end else begin
        acc_nxt  = {13'd0, b & Lead4Bits};
        pend_nxt = 2'd3;
      end
      seq_nxt = pos_r;
      pos_nxt = pos_inc;
      if (eos) begin
        has_res      = 1'b1;
        res.status   = ST_TRUNC;
        res.done_res = 1'b1;
        res.consumed = pos_r;
        clear        = 1'b1;
      end
    end
    res.char_word = swap ? byte_swap(word) : word;
    if (clear) begin
      acc_nxt  = '0;
      pend_nxt = '0;
      pos_nxt  = '0;
      seq_nxt  = '0;
      skip_nxt = 1'b0;
    end
    // an invalid lead that does not end the string swallows the rest of it
    if (!skip_r && pend_r == 2'd0 && !(b < AsciiLimit) &&
        (b < LeadLow || b > LeadHigh)) begin
      skip_nxt = !eos;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      pend_r <= '0;
      pos_r  <= '0;
      seq_r  <= '0;
      skip_r <= 1'b0;
    end else if (fire) begin
      acc_r  <= acc_nxt;
      pend_r <= pend_nxt;
      pos_r  <= pos_nxt;
      seq_r  <= seq_nxt;
      skip_r <= skip_nxt;
    end
  end
endmodule

// ----- hdl/u2u_out_stage.sv -----
// result register stage driving the output channel
// depends on u2u_pkg and u2u_out_if
module u2u_out_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  input  u2u_pkg::res_t res,
  u2u_out_if.source     out_ch,
  output logic          free
);
  import u2u_pkg::*;

  logic valid_r;
  logic valid_nxt;
  res_t res_r;

  assign free = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_ch.valid      = valid_r;
  assign out_ch.char_word  = res_r.char_word;
  assign out_ch.word_valid = res_r.word_valid;
  assign out_ch.status     = res_r.status;
  assign out_ch.done_res   = res_r.done_res;
  assign out_ch.consumed   = res_r.consumed;
endmodule

// ----- hdl/utf8_to_utf32_stream_decoder.sv -----
// path: accepted item -> input reg -> decode -> result reg
// throughput: one byte item per cycle while the result reg is free, set by the
// single-pass decode between the two regs; bytes without a result still pass
// reset: synchronous active-low rst_n clears both stage valids, string state
// and the swap register
`include "utf8_to_utf32_stream_decoder_assert.svh"

module utf8_to_utf32_stream_decoder (
  input  logic       clk,
  input  logic       rst_n,
  u2u_in_if.sink     in_ch,
  u2u_out_if.source  out_ch,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data
);
  import u2u_pkg::*;

  logic     swap_r;
  logic     s1_valid;
  in_item_t s1_item;
  logic     free;
  logic     fire;
  logic     has_res;
  res_t     res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      swap_r <= 1'b0;
    end else if (cfg_wr_en) begin
      swap_r <= cfg_wr_data;
    end
  end

  assign fire = s1_valid && free;

  u2u_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .take       (fire),
    .item_valid (s1_valid),
    .item       (s1_item)
  );

  u2u_decode u_dec (
    .clk     (clk),
    .rst_n   (rst_n),
    .swap    (swap_r),
    .fire    (fire),
    .item    (s1_item),
    .has_res (has_res),
    .res     (res)
  );

  u2u_out_stage u_out (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (fire && has_res),
    .res    (res),
    .out_ch (out_ch),
    .free   (free)
  );

  `U2U_ASSERT_NOW(a_zero_word, out_ch.valid && !out_ch.word_valid, out_ch.char_word == 32'd0, "word not zero on non-character item")
  `U2U_ASSERT_NOW(a_err_done, out_ch.valid && out_ch.status != ST_OK, out_ch.done_res && !out_ch.word_valid, "error item not final")
  `U2U_ASSERT_NOW(a_consumed_zero, out_ch.valid && !out_ch.done_res, out_ch.consumed == 16'd0, "consumed set before end of string")
  `U2U_ASSERT_NEXT(a_result_lands, fire && has_res, out_ch.valid, "decoded result lost")

endmodule
